// ===== src/obds_pkg.sv =====
// Package for the octave-band energy sum: transaction structs, fixed-point
// constants and the exp2 root table, built at elaboration.
// No dependencies.
package obds_pkg;

    localparam int BAND_COUNT  = 8;
    localparam int LEVEL_W     = 12;
    localparam int TAG_W       = 2;
    localparam int FRAC_BITS   = 16;
    localparam int LOG_BITS    = 20;

    localparam logic [19:0] LOG2_10_Q24    = 20'd557327;
    localparam logic [20:0] DB_PER_OCT_Q16 = 21'd1972830;
    localparam logic signed [12:0] OUT_MIN = -13'sd200;
    localparam logic signed [12:0] OUT_MAX = 13'sd1700;

    typedef struct packed {
        logic [TAG_W-1:0]          channel_tag;
        logic signed [LEVEL_W-1:0] band_63hz;
        logic signed [LEVEL_W-1:0] band_125hz;
        logic signed [LEVEL_W-1:0] band_250hz;
        logic signed [LEVEL_W-1:0] band_500hz;
        logic signed [LEVEL_W-1:0] band_1khz;
        logic signed [LEVEL_W-1:0] band_2khz;
        logic signed [LEVEL_W-1:0] band_4khz;
        logic signed [LEVEL_W-1:0] band_8khz;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]          channel_out;
        logic signed [LEVEL_W-1:0] total_level;
    } t_out_item;

    typedef logic [FRAC_BITS:0][31:0] t_root_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = x;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Entry k is 2^(-2^-k) in Q30; entry 0 is 1.0.
    function automatic t_root_tab build_roots();
        t_root_tab   tab;
        logic [63:0] r64;
        tab[0] = 32'd1 << 30;
        r64    = isqrt64(64'd1 << 59);
        tab[1] = r64[31:0];
        for (int k = 2; k <= FRAC_BITS; k++) begin
            r64    = isqrt64({32'd0, tab[k-1]} << 30);
            tab[k] = r64[31:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = build_roots();

endpackage

// ===== src/octave_band_db_sum.sv =====
// Octave-band energy sum, top level: a fully pipelined datapath.
// Depends on obds_pkg (structs, constants, root table).
//
//  channel   direction  handshake          payload
//  command   in         start / busy       i_item   (t_in_item)
//  result    out        o_strobe (1 cycle) o_result (t_out_item)
//
// One transaction enters per cycle; busy is always low.
// The datapath has 16 exp2 root multiply stages and 20 log2 squaring stages,
// one multiplier step per stage, plus eight stages of compare, add and scale.
// Synchronous active-low reset clears only the valid bits.
// The receiver cannot stall, so the pipeline never holds.
module octave_band_db_sum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  obds_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_strobe,
    output obds_pkg::t_out_item  o_result
);
    import obds_pkg::*;

    localparam int NPOW = FRAC_BITS;          // exp2 root stages
    localparam int NSQ  = LOG_BITS;           // log2 squaring stages
    localparam int NDL  = NPOW + NSQ + 5;     // stages from C to G
    localparam int NVLD = NDL + 2;
    localparam int SQ0  = NPOW + 4;           // delay index of first squaring stage

    function automatic logic [30:0] root_step(input logic [30:0] p, input logic [29:0] t);
        logic [60:0] prod;
        prod = p * t;
        return prod[60:30];
    endfunction

    logic [NVLD-1:0] r_vld;

    // stage A
    logic [TAG_W-1:0]          r_a_tag;
    logic signed [LEVEL_W-1:0] r_a_lv [BAND_COUNT];
    // stage B
    logic [TAG_W-1:0]          r_b_tag;
    logic signed [LEVEL_W-1:0] r_b_lmax;
    logic [LEVEL_W-1:0]        r_b_d [BAND_COUNT];
    // stage C
    logic [7:0]                r_c_n [BAND_COUNT];
    logic [FRAC_BITS-1:0]      r_c_f [BAND_COUNT];
    // root chain
    logic [30:0]               r_pw [NPOW][BAND_COUNT];
    logic [FRAC_BITS-1:0]      r_pf [NPOW][BAND_COUNT];
    logic [7:0]                r_pn [NPOW][BAND_COUNT];
    // stages D, E, F
    logic [30:0]               r_d_pow [BAND_COUNT];
    logic [33:0]               r_e_sum;
    logic [1:0]                r_f_p;
    logic [30:0]               r_f_m;
    // squaring chain
    logic [30:0]               r_sq_m  [NSQ];
    logic [NSQ-1:0]            r_sq_fr [NSQ];
    logic [1:0]                r_sq_p  [NSQ];
    // stage G
    logic [6:0]                r_g_inc;
    // side delay line
    logic [TAG_W-1:0]          r_dl_tag  [NDL];
    logic signed [LEVEL_W-1:0] r_dl_lmax [NDL];
    t_out_item                 r_out;

    logic signed [LEVEL_W-1:0] n_lv [BAND_COUNT];
    logic signed [LEVEL_W-1:0] n_lmax;
    logic [31:0]               n_e [BAND_COUNT];
    logic [30:0]               n_pw [NPOW][BAND_COUNT];
    logic [33:0]               n_sum;
    logic [1:0]                n_p;
    logic [33:0]               n_mshift;
    logic [61:0]               n_sq [NSQ];
    logic [31:0]               n_sqt [NSQ];
    logic [42:0]               n_incp;
    logic signed [12:0]        n_total;
    logic signed [LEVEL_W-1:0] n_clamp;

    assign n_lv[0] = i_item.band_63hz;
    assign n_lv[1] = i_item.band_125hz;
    assign n_lv[2] = i_item.band_250hz;
    assign n_lv[3] = i_item.band_500hz;
    assign n_lv[4] = i_item.band_1khz;
    assign n_lv[5] = i_item.band_2khz;
    assign n_lv[6] = i_item.band_4khz;
    assign n_lv[7] = i_item.band_8khz;

    assign busy = 1'b0;

    always_comb begin
        n_lmax = r_a_lv[0];
        for (int b = 1; b < BAND_COUNT; b++) begin
            if (r_a_lv[b] > n_lmax) begin
                n_lmax = r_a_lv[b];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < BAND_COUNT; b++) begin
            n_e[b] = r_b_d[b] * LOG2_10_Q24;
        end
    end

    // Multiply by root k when fraction bit of weight 2^-k is set.
    always_comb begin
        for (int j = 0; j < NPOW; j++) begin
            for (int b = 0; b < BAND_COUNT; b++) begin
                if (j == 0) begin
                    n_pw[j][b] = r_c_f[b][FRAC_BITS-1]
                               ? root_step(31'd1 << 30, ROOT_TAB[1][29:0])
                               : 31'd1 << 30;
                end else begin
                    n_pw[j][b] = r_pf[j-1][b][FRAC_BITS-1-j]
                               ? root_step(r_pw[j-1][b], ROOT_TAB[j+1][29:0])
                               : r_pw[j-1][b];
                end
            end
        end
    end

    always_comb begin
        n_sum = 34'd0;
        for (int b = 0; b < BAND_COUNT; b++) begin
            n_sum = n_sum + {3'd0, r_d_pow[b]};
        end
    end

    always_comb begin
        priority if (r_e_sum[33]) n_p = 2'd3;
        else if (r_e_sum[32])     n_p = 2'd2;
        else if (r_e_sum[31])     n_p = 2'd1;
        else                      n_p = 2'd0;
        n_mshift = r_e_sum >> n_p;
    end

    always_comb begin
        for (int j = 0; j < NSQ; j++) begin
            if (j == 0) begin
                n_sq[j] = r_f_m * r_f_m;
            end else begin
                n_sq[j] = r_sq_m[j-1] * r_sq_m[j-1];
            end
            n_sqt[j] = n_sq[j][61:30];
        end
    end

    always_comb begin
        n_incp  = {r_sq_p[NSQ-1], r_sq_fr[NSQ-1]} * DB_PER_OCT_Q16 + (43'd1 << 35);
        n_total = 13'(r_dl_lmax[NDL-1]) + $signed({6'd0, r_g_inc});
        priority if (n_total < OUT_MIN) n_clamp = OUT_MIN[LEVEL_W-1:0];
        else if (n_total > OUT_MAX)     n_clamp = OUT_MAX[LEVEL_W-1:0];
        else                            n_clamp = n_total[LEVEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[NVLD-2:0], start && !busy};
            o_strobe <= r_vld[NVLD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_tag  <= i_item.channel_tag;
        r_a_lv   <= n_lv;
        r_b_tag  <= r_a_tag;
        r_b_lmax <= n_lmax;
        for (int b = 0; b < BAND_COUNT; b++) begin
            r_b_d[b]   <= LEVEL_W'(13'(n_lmax) - 13'(r_a_lv[b]));
            r_c_n[b]   <= n_e[b][31:24];
            r_c_f[b]   <= n_e[b][23:8];
            r_d_pow[b] <= (r_pn[NPOW-1][b] >= 8'd31) ? 31'd0
                        : r_pw[NPOW-1][b] >> r_pn[NPOW-1][b][4:0];
        end
        for (int j = 0; j < NPOW; j++) begin
            r_pw[j] <= n_pw[j];
            for (int b = 0; b < BAND_COUNT; b++) begin
                r_pf[j][b] <= (j == 0) ? r_c_f[b] : r_pf[j-1][b];
                r_pn[j][b] <= (j == 0) ? r_c_n[b] : r_pn[j-1][b];
            end
        end
        r_e_sum <= n_sum;
        r_f_p   <= n_p;
        r_f_m   <= n_mshift[30:0];
        // Set the fraction bit and halve when the square reaches 2.0.
        for (int j = 0; j < NSQ; j++) begin
            r_sq_m[j]  <= n_sqt[j][31] ? n_sqt[j][31:1] : n_sqt[j][30:0];
            r_sq_fr[j] <= ((j == 0) ? '0 : r_sq_fr[j-1])
                        | (NSQ'(n_sqt[j][31]) << (NSQ-1-j));
            r_sq_p[j]  <= (j == 0) ? r_f_p : r_sq_p[j-1];
        end
        r_g_inc <= n_incp[42:36];
        for (int j = 0; j < NDL; j++) begin
            r_dl_tag[j]  <= (j == 0) ? r_b_tag  : r_dl_tag[j-1];
            r_dl_lmax[j] <= (j == 0) ? r_b_lmax : r_dl_lmax[j-1];
        end
        r_out.channel_out <= r_dl_tag[NDL-1];
        r_out.total_level <= n_clamp;
    end

    assign o_result = r_out;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(NVLD+1) o_strobe)
        else $error("result strobe missing after accepted transaction");

    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($signed(o_result.total_level) >= -12'sd200 &&
                      $signed(o_result.total_level) <= 12'sd1700))
        else $error("total level outside saturation range");

    a_norm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SQ0+1] |-> r_f_m[30])
        else $error("log2 mantissa not normalized");

endmodule
